### hw/rtl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared constants, codes and controller/datapath interface types for the
// rectangle raster canvas.
// ----------------------------------------------------------------------------
package rrc_pkg;

    localparam int MAX_COLS_DEF  = 256;
    localparam int MAX_ROWS_DEF  = 256;
    localparam int FRAC_BITS_DEF = 8;

    localparam int FIELD_W = 24;
    localparam int CFG_W   = 9;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_REJECT  = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    localparam logic [7:0] SHAPE_OUTLINE = 8'h72;
    localparam logic [7:0] SHAPE_FILLED  = 8'h52;

    localparam int         REG_ADDR_W         = 4;
    localparam logic [1:0] REG_CANVAS_WIDTH   = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_BACKGROUND     = 2'd2;

    localparam logic [CFG_W-1:0] CANVAS_WIDTH_RST  = 9'd256;
    localparam logic [CFG_W-1:0] CANVAS_HEIGHT_RST = 9'd256;
    localparam logic [7:0]       BACKGROUND_RST    = 8'd32;

    typedef struct packed {
        logic load_in;
        logic clr_cnt;
        logic ld_bounds;
        logic sweep_en;
        logic rd_issue;
        logic rd_take;
        logic zero_value;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       rect_ok;
        logic       rd_in_range;
        logic       sweep_last;
    } t_dp_stat;

endpackage

### hw/rtl/rrc_ctrl.sv
// ----------------------------------------------------------------------------
// rrc_ctrl
// Command sequencer: accepts a word, decides clear/draw/read handling, runs
// the pixel sweep and hands the result to the output register.
// ----------------------------------------------------------------------------
module rrc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output rrc_pkg::t_dp_cmd  o_cmd,
    input  rrc_pkg::t_dp_stat i_stat,
    input  logic              i_out_free,
    output logic              o_res_load,
    output logic [1:0]        o_status
);
    import rrc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_job_failed, n_job_failed;
    logic [1:0] r_status, n_status;

    always_comb begin
        n_state      = r_state;
        n_job_failed = r_job_failed;
        n_status     = r_status;
        o_cmd        = '0;
        o_res_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.clr_cnt    = 1'b1;
                o_cmd.ld_bounds  = 1'b1;
                o_cmd.zero_value = 1'b1;
                n_status         = STAT_DONE;
                n_state          = ST_DONE;
                unique case (i_stat.cmd)
                    CMD_CLEAR: begin
                        n_job_failed = 1'b0;
                        n_state      = ST_SWEEP;
                    end
                    CMD_DRAW: begin
                        priority if (r_job_failed) begin
                            n_status = STAT_REFUSED;
                        end else if (!i_stat.rect_ok) begin
                            n_job_failed = 1'b1;
                            n_status     = STAT_REJECT;
                        end else begin
                            n_state = ST_SWEEP;
                        end
                    end
                    CMD_READ: begin
                        priority if (r_job_failed) begin
                            n_status = STAT_REFUSED;
                        end else if (i_stat.rd_in_range) begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = ST_RDWAIT;
                        end else begin
                            n_status = STAT_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SWEEP: begin
                o_cmd.sweep_en = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_RDWAIT: begin
                o_cmd.rd_take = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_job_failed <= 1'b0;
            r_status     <= STAT_DONE;
        end else begin
            r_state      <= n_state;
            r_job_failed <= n_job_failed;
            r_status     <= n_status;
        end
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign o_status = r_status;

endmodule

### hw/rtl/rrc_dpath.sv
// ----------------------------------------------------------------------------
// rrc_dpath
// Canvas store, sweep counters, rectangle edge classification and the
// single-pixel read path.
// ----------------------------------------------------------------------------
module rrc_dpath #(
    parameter int MAX_COLS  = rrc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = rrc_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = rrc_pkg::FRAC_BITS_DEF,
    parameter int CW        = $clog2(MAX_COLS + 1),
    parameter int RW        = $clog2(MAX_ROWS + 1)
) (
    input  logic                               i_clk,
    input  rrc_pkg::t_dp_cmd                   i_cmd,
    output rrc_pkg::t_dp_stat                  o_stat,
    input  logic [1:0]                         i_cmd_code,
    input  logic [7:0]                         i_shape_char,
    input  logic signed [rrc_pkg::FIELD_W-1:0] i_rect_left,
    input  logic signed [rrc_pkg::FIELD_W-1:0] i_rect_top,
    input  logic signed [rrc_pkg::FIELD_W-1:0] i_rect_width,
    input  logic signed [rrc_pkg::FIELD_W-1:0] i_rect_height,
    input  logic [7:0]                         i_paint_char,
    input  logic [7:0]                         i_pixel_col,
    input  logic [7:0]                         i_pixel_row,
    input  logic [CW-1:0]                      i_cols,
    input  logic [RW-1:0]                      i_rows,
    input  logic [7:0]                         i_bg_char,
    output logic [7:0]                         o_pixel_value
);
    import rrc_pkg::*;

    localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PW    = ((XW > YW) ? XW : YW) + FRAC_BITS + 1;
    localparam int BW    = (PW > FIELD_W + 2) ? PW : FIELD_W + 2;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic signed [BW-1:0] ONE_FX = BW'(1) << FRAC_BITS;

    logic [1:0]                 r_cmd;
    logic [7:0]                 r_shape;
    logic signed [FIELD_W-1:0]  r_left, r_top, r_wid, r_hgt;
    logic [7:0]                 r_paint;
    logic [7:0]                 r_col, r_row;

    logic signed [BW-1:0] r_xl, r_xl1, r_xr, r_xr1;
    logic signed [BW-1:0] r_yt, r_yt1, r_yb, r_yb1;

    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;

    logic [7:0] r_canvas [DEPTH];
    logic [7:0] r_rd_data;
    logic [7:0] r_value;

    logic signed [BW-1:0] px, qy;
    logic                 x_last, y_last, in_rect, border, paint;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [7:0]           wr_data;

    always_comb begin
        px      = $signed(BW'(r_x) << FRAC_BITS);
        qy      = $signed(BW'(r_y) << FRAC_BITS);
        x_last  = (CW'(r_x) == i_cols - CW'(1));
        y_last  = (RW'(r_y) == i_rows - RW'(1));
        in_rect = (px >= r_xl) && (px <= r_xr) && (qy >= r_yt) && (qy <= r_yb);
        border  = (px < r_xl1) || (px > r_xr1) || (qy < r_yt1) || (qy > r_yb1);
        if (r_cmd == CMD_CLEAR) begin
            paint   = 1'b1;
            wr_data = i_bg_char;
        end else begin
            paint   = in_rect && (border || (r_shape == SHAPE_FILLED));
            wr_data = r_paint;
        end
        wr_addr = AW'(r_y) * AW'(MAX_COLS) + AW'(r_x);
        rd_addr = AW'(r_row) * AW'(MAX_COLS) + AW'(r_col);
    end

    always_comb begin
        o_stat.cmd         = r_cmd;
        o_stat.rect_ok     = (r_wid > 0) && (r_hgt > 0) &&
                             ((r_shape == SHAPE_OUTLINE) || (r_shape == SHAPE_FILLED));
        o_stat.rd_in_range = (32'(r_col) < 32'(i_cols)) && (32'(r_row) < 32'(i_rows));
        o_stat.sweep_last  = x_last && y_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd   <= i_cmd_code;
            r_shape <= i_shape_char;
            r_left  <= i_rect_left;
            r_top   <= i_rect_top;
            r_wid   <= i_rect_width;
            r_hgt   <= i_rect_height;
            r_paint <= i_paint_char;
            r_col   <= i_pixel_col;
            r_row   <= i_pixel_row;
        end
        if (i_cmd.ld_bounds) begin
            r_xl  <= BW'(r_left);
            r_xl1 <= BW'(r_left) + ONE_FX;
            r_xr  <= BW'(r_left) + BW'(r_wid);
            r_xr1 <= BW'(r_left) + BW'(r_wid) - ONE_FX;
            r_yt  <= BW'(r_top);
            r_yt1 <= BW'(r_top) + ONE_FX;
            r_yb  <= BW'(r_top) + BW'(r_hgt);
            r_yb1 <= BW'(r_top) + BW'(r_hgt) - ONE_FX;
        end
        if (i_cmd.clr_cnt) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.sweep_en) begin
            if (x_last) begin
                r_x <= '0;
                r_y <= r_y + YW'(1);
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
        if (i_cmd.zero_value) begin
            r_value <= '0;
        end else if (i_cmd.rd_take) begin
            r_value <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_en && paint) begin
            r_canvas[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_canvas[rd_addr];
        end
    end

    assign o_pixel_value = r_value;

endmodule

### hw/rtl/rectangle_raster_canvas_unit.sv
// ----------------------------------------------------------------------------
// rectangle_raster_canvas_unit: one word at a time. Clear and an accepted
// draw sweep all cols*rows pixels (one pixel per cycle on the canvas write
// port); next word accepted once the result is registered.
// Synchronous reset clears control only; canvas holds garbage until a clear.
// ----------------------------------------------------------------------------
module rectangle_raster_canvas_unit #(
    parameter int MAX_COLS  = rrc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = rrc_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = rrc_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rrc_pkg::REG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_cmd,
    input  logic [7:0]                         i_shape_char,
    input  logic signed [rrc_pkg::FIELD_W-1:0] i_rect_left,
    input  logic signed [rrc_pkg::FIELD_W-1:0] i_rect_top,
    input  logic signed [rrc_pkg::FIELD_W-1:0] i_rect_width,
    input  logic signed [rrc_pkg::FIELD_W-1:0] i_rect_height,
    input  logic [7:0]                         i_paint_char,
    input  logic [7:0]                         i_pixel_col,
    input  logic [7:0]                         i_pixel_row,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_status,
    output logic [7:0]                         o_pixel_value
);
    import rrc_pkg::*;

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic [CFG_W-1:0] r_canvas_width, r_canvas_height;
    logic [7:0]       r_background;
    logic [CW-1:0]    cols;
    logic [RW-1:0]    rows;

    t_dp_cmd    dp_cmd;
    t_dp_stat   dp_stat;
    logic       res_load, out_free;
    logic [1:0] res_status;
    logic [7:0] res_value;

    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [7:0] r_out_value;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= CANVAS_WIDTH_RST;
            r_canvas_height <= CANVAS_HEIGHT_RST;
            r_background    <= BACKGROUND_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_CANVAS_WIDTH:  r_canvas_width  <= pwdata[CFG_W-1:0];
                REG_CANVAS_HEIGHT: r_canvas_height <= pwdata[CFG_W-1:0];
                REG_BACKGROUND:    r_background    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CANVAS_WIDTH:  prdata = 32'(r_canvas_width);
            REG_CANVAS_HEIGHT: prdata = 32'(r_canvas_height);
            REG_BACKGROUND:    prdata = 32'(r_background);
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // active size: zero acts as one, oversize clamps to the maximum
    always_comb begin
        priority if (r_canvas_width == '0) begin
            cols = CW'(1);
        end else if (32'(r_canvas_width) > 32'(MAX_COLS)) begin
            cols = CW'(MAX_COLS);
        end else begin
            cols = CW'(r_canvas_width);
        end
        priority if (r_canvas_height == '0) begin
            rows = RW'(1);
        end else if (32'(r_canvas_height) > 32'(MAX_ROWS)) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(r_canvas_height);
        end
    end

    rrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_status   (res_status)
    );

    rrc_dpath #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW),
        .RW        (RW)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cmd_code    (i_cmd),
        .i_shape_char  (i_shape_char),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_paint_char  (i_paint_char),
        .i_pixel_col   (i_pixel_col),
        .i_pixel_row   (i_pixel_row),
        .i_cols        (cols),
        .i_rows        (rows),
        .i_bg_char     (r_background),
        .o_pixel_value (res_value)
    );

    // result word register
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_status <= res_status;
            r_out_value  <= res_value;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_pixel_value = r_out_value;

endmodule
